// File: hw/rtl/pq4_pkg.sv
// Shared constants and types for the 4-bit PQ lookup-table distance scan.
package pq4_pkg;

  // Table geometry: one row of LEVELS entries per coordinate
  localparam int unsigned MAX_DIMS  = 2048;
  localparam int unsigned LEVELS    = 16;
  localparam int unsigned LVL_W     = $clog2(LEVELS);
  localparam int unsigned POS_W     = $clog2(MAX_DIMS);
  localparam int unsigned CNT_W     = POS_W + 1;
  localparam int unsigned TBL_DEPTH = MAX_DIMS * LEVELS;
  localparam int unsigned TBL_AW    = $clog2(TBL_DEPTH);

  // Field widths
  localparam int unsigned DIMS_W  = 12;
  localparam int unsigned IDX_W   = 15;
  localparam int unsigned VAL_W   = 8;
  localparam int unsigned CODE_W  = 8;
  localparam int unsigned SUM_W   = 20;
  localparam int unsigned SCORE_W = 19;

  localparam logic [DIMS_W-1:0] DIMS_RESET = DIMS_W'(2048);
  localparam logic [CODE_W-1:0] NIB_MASK   = CODE_W'(8'h0F);

  typedef enum logic [0:0] {
    CMD_LOAD = 1'b0,
    CMD_CODE = 1'b1
  } cmd_e;

endpackage

// File: hw/rtl/pq4_table_ram.sv
// Lookup-table RAM: one write port, two registered read ports.
module pq4_table_ram (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [pq4_pkg::TBL_AW-1:0]           waddr_i,
  input  logic [pq4_pkg::VAL_W-1:0]            wdata_i,
  input  logic                                 re_i,
  input  logic [pq4_pkg::TBL_AW-1:0]           raddr_a_i,
  input  logic [pq4_pkg::TBL_AW-1:0]           raddr_b_i,
  output logic [pq4_pkg::VAL_W-1:0]            rdata_a_o,
  output logic [pq4_pkg::VAL_W-1:0]            rdata_b_o
);

  logic [pq4_pkg::VAL_W-1:0] mem [pq4_pkg::TBL_DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem[raddr_a_i];
      rdata_b_o <= mem[raddr_b_i];
    end
  end

endmodule

// File: hw/rtl/pq4_lut_distance_scan.sv
// Top level: 4-bit PQ fast-scan scorer over a per-query lookup table.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one command per transfer.
//   cmd_i = load: table_value_i is written at table_index_i (coordinate*16 +
//   level); indexes past the table are dropped. cmd_i = code: code_byte_i holds
//   two codes, low nibble for the even coordinate, high nibble for the odd one.
//   The two selected entries are read in the same cycle and added to a running sum.
//   When dims_in_use coordinates are summed, score_o is presented on the output
//   channel (out_valid_o / out_stall_i) and the sum restarts; for an odd count
//   the last high nibble is ignored.
//   cfg_we_i / cfg_wdata_i write dims_in_use (0 acts as 1, values above 2048 act
//   as 2048); write only while idle.
// Timing:
//   One transfer per cycle sustained while the output is not stalled. A code
//   transfer passes through the table RAM read register, then the accumulate
//   into the output register.
//   A table load is visible to a code byte taken in the very next cycle.
// Reset:
//   Clears the coordinate position, running sum, pipeline valids and sets
//   dims_in_use to 2048. Table contents are undefined until loaded.
// Stall:
//   A stalled score holds on the output; the read stage keeps its data and the
//   input stalls only when that stage is full and cannot drain.
module pq4_lut_distance_scan (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               cfg_we_i,
  input  logic [pq4_pkg::DIMS_W-1:0]         cfg_wdata_i,
  // input channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               cmd_i,
  input  logic [pq4_pkg::IDX_W-1:0]          table_index_i,
  input  logic [pq4_pkg::VAL_W-1:0]          table_value_i,
  input  logic [pq4_pkg::CODE_W-1:0]         code_byte_i,
  // output channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [pq4_pkg::SCORE_W-1:0]        score_o
);

  localparam int unsigned CNT_W = pq4_pkg::CNT_W;
  localparam int unsigned POS_W = pq4_pkg::POS_W;
  localparam int unsigned LVL_W = pq4_pkg::LVL_W;

  // Clamp the programmed count into 1..MAX_DIMS
  function automatic logic [CNT_W-1:0] clamp_dims(input logic [pq4_pkg::DIMS_W-1:0] d);
    logic [pq4_pkg::DIMS_W:0] dx;
    logic [CNT_W-1:0]         r;
    dx = {1'b0, d};
    if (d == '0) begin
      r = CNT_W'(1);
    end else if (dx > (pq4_pkg::DIMS_W + 1)'(pq4_pkg::MAX_DIMS)) begin
      r = CNT_W'(pq4_pkg::MAX_DIMS);
    end else begin
      r = CNT_W'(d);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Configuration: effective dimension count
  // ---------------------------------------------------------------------
  logic [CNT_W-1:0] dims_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q <= clamp_dims(pq4_pkg::DIMS_RESET);
    end else if (cfg_we_i) begin
      dims_q <= clamp_dims(cfg_wdata_i);
    end
  end

  // ---------------------------------------------------------------------
  // Input transfer and handshake
  // ---------------------------------------------------------------------
  logic s1_valid_q, s1_last_q, s1_use_hi_q;
  logic out_valid_q;
  logic s1_adv;
  logic in_accept, load_accept, code_accept;

  // Read stage drains unless it holds a final coordinate and the output is
  // full and stalled
  assign s1_adv      = s1_valid_q & (~s1_last_q | ~out_valid_q | ~out_stall_i);
  assign in_stall_o  = s1_valid_q & ~s1_adv;
  assign in_accept   = in_valid_i & ~in_stall_o;
  assign code_accept = in_accept & (cmd_i == pq4_pkg::CMD_CODE);
  assign load_accept = in_accept & (cmd_i == pq4_pkg::CMD_LOAD);

  // ---------------------------------------------------------------------
  // Coordinate tracking, done at transfer time
  // ---------------------------------------------------------------------
  logic [POS_W-1:0] pos_q, pos_d;
  logic [CNT_W-1:0] pos_p1, pos_p2;
  logic             done_lo, done_hi, vec_last;

  assign pos_p1   = {1'b0, pos_q} + CNT_W'(1);
  assign pos_p2   = pos_p1 + CNT_W'(1);
  assign done_lo  = (pos_p1 >= dims_q);
  assign done_hi  = (pos_p2 >= dims_q);
  assign vec_last = done_lo | done_hi;

  always_comb begin
    pos_d = pos_q;
    if (code_accept) begin
      pos_d = vec_last ? '0 : pos_p2[POS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  // ---------------------------------------------------------------------
  // Table RAM: write on load, two reads on code byte
  // ---------------------------------------------------------------------
  logic [pq4_pkg::CODE_W-1:0] code_lo, code_hi;
  logic [pq4_pkg::TBL_AW-1:0] raddr_a, raddr_b, waddr;
  logic                       wr_in_range;
  logic [pq4_pkg::VAL_W-1:0]  rd_a, rd_b;

  assign code_lo = code_byte_i & pq4_pkg::NIB_MASK;
  assign code_hi = (code_byte_i >> LVL_W) & pq4_pkg::NIB_MASK;
  assign raddr_a = {pos_q, code_lo[LVL_W-1:0]};
  assign raddr_b = {pos_p1[POS_W-1:0], code_hi[LVL_W-1:0]};

  assign wr_in_range = ({1'b0, table_index_i} < (pq4_pkg::IDX_W + 1)'(pq4_pkg::TBL_DEPTH));
  assign waddr       = pq4_pkg::TBL_AW'(table_index_i);

  pq4_table_ram u_table (
    .clk_i     (clk_i),
    .we_i      (load_accept & wr_in_range),
    .waddr_i   (waddr),
    .wdata_i   (table_value_i),
    .re_i      (code_accept),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  // Read stage control; data lives in the RAM output registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (code_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (code_accept) begin
      s1_last_q   <= vec_last;
      s1_use_hi_q <= ~done_lo;
    end
  end

  // ---------------------------------------------------------------------
  // Accumulate and output register
  // ---------------------------------------------------------------------
  logic [pq4_pkg::VAL_W:0]     pair_sum;
  logic [pq4_pkg::SUM_W-1:0]   sum_q, sum_next;
  logic [pq4_pkg::SCORE_W-1:0] score_q;

  assign pair_sum = {1'b0, rd_a} + (s1_use_hi_q ? {1'b0, rd_b} : '0);
  assign sum_next = sum_q + pq4_pkg::SUM_W'(pair_sum);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (s1_adv) begin
      sum_q <= s1_last_q ? '0 : sum_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv & s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (~out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv & s1_last_q) begin
      score_q <= sum_next[pq4_pkg::SCORE_W-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign score_o     = score_q;

endmodule

// File: hw/rtl/pq4_checker.sv
// Port-level checker for the PQ scan block, bound to the top level.
module pq4_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic                               cmd_i,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic [pq4_pkg::SCORE_W-1:0]        score_o
);

  logic code_xfer;
  assign code_xfer = in_valid_i & ~in_stall_o & (cmd_i == pq4_pkg::CMD_CODE);

  // Stalled score holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(score_o))
    else $error("score changed or dropped while stalled");

  // A newly valid score must trace back to an earlier code transfer
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(code_xfer, 2))
    else $error("score appeared without a code transfer");

  // Input never stalls while the output register is empty
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  // Score never exceeds the full-table maximum
  a_score_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, score_o} <= (pq4_pkg::SCORE_W + 1)'(
      pq4_pkg::MAX_DIMS * ((1 << pq4_pkg::VAL_W) - 1))))
    else $error("score above maximum");

endmodule

bind pq4_lut_distance_scan pq4_checker u_checker (.*);
